[rtl/piecewise_linear_contrast_stretch_core_defines.svh]
`ifndef PIECEWISE_LINEAR_CONTRAST_STRETCH_CORE_DEFINES_SVH
`define PIECEWISE_LINEAR_CONTRAST_STRETCH_CORE_DEFINES_SVH

// implication checked in the same cycle
`ifndef ASSERT_OFF
`define PLCS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("plcs assertion failed");
`else
`define PLCS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`endif

// consequence checked after the delay given by dly
`ifndef ASSERT_OFF
`define PLCS_ASSERT_DLY(lbl, clk, rst, ante, dly, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error("plcs assertion failed");
`else
`define PLCS_ASSERT_DLY(lbl, clk, rst, ante, dly, cons)
`endif

`endif

[rtl/plcs_pkg.sv]
package plcs_pkg;

   localparam int PIXEL_BITS_DEF = 8;
   localparam int CSR_INDEX_BITS = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_LOW_THRESHOLD  = 2'd0,
      CSR_HIGH_THRESHOLD = 2'd1,
      CSR_LOW_LEVEL      = 2'd2,
      CSR_HIGH_LEVEL     = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      REGION_LOW   = 2'd0,
      REGION_HIGH  = 2'd1,
      REGION_RAMP  = 2'd2,
      REGION_ERROR = 2'd3
   } region_type;

   typedef struct packed {
      region_type region;
      logic       neg;
   } side_type;

   localparam int SIDE_BITS = $bits(side_type);

endpackage

[rtl/plcs_divider.sv]
module plcs_divider
   import plcs_pkg::*;
#(
   parameter int PIXEL_BITS = PIXEL_BITS_DEF,
   parameter int SIDE_W     = SIDE_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [2*PIXEL_BITS:0]   in_num,
   input  logic [PIXEL_BITS:0]     in_den,
   input  logic [SIDE_W-1:0]       in_side,
   output logic                    out_valid,
   output logic [PIXEL_BITS:0]     out_quot,
   output logic                    out_rem_nz,
   output logic [SIDE_W-1:0]       out_side
);

   localparam int N_W = 2*PIXEL_BITS + 1;
   localparam int Q_W = PIXEL_BITS + 1;

   logic           valid_ff [Q_W];
   logic [N_W-1:0] rem_ff   [Q_W];
   logic [Q_W-1:0] quot_ff  [Q_W];
   logic [SIDE_W-1:0] side_ff [Q_W];

   logic           src_valid [Q_W];
   logic [N_W-1:0] src_rem   [Q_W];
   logic [Q_W-1:0] src_quot  [Q_W];
   logic [SIDE_W-1:0] src_side [Q_W];

   logic [N_W-1:0] rem_in  [Q_W];
   logic [Q_W-1:0] quot_in [Q_W];

   // one quotient bit per stage; divisor steady during transactions is up to the user
   for (genvar k = 0; k < Q_W; k++) begin : g_stage
      logic [N_W-1:0] den_shift;
      logic           fits;

      if (k == 0) begin : g_first
         assign src_valid[k] = in_valid;
         assign src_rem[k]   = in_num;
         assign src_quot[k]  = '0;
         assign src_side[k]  = in_side;
      end else begin : g_next
         assign src_valid[k] = valid_ff[k-1];
         assign src_rem[k]   = rem_ff[k-1];
         assign src_quot[k]  = quot_ff[k-1];
         assign src_side[k]  = side_ff[k-1];
      end

      always_comb begin
         den_shift  = N_W'(in_den) << (Q_W - 1 - k);
         fits       = src_rem[k] >= den_shift;
         rem_in[k]  = fits ? src_rem[k] - den_shift : src_rem[k];
         quot_in[k] = {src_quot[k][Q_W-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= src_valid[k];
         end
         rem_ff[k]  <= rem_in[k];
         quot_ff[k] <= quot_in[k];
         side_ff[k] <= src_side[k];
      end
   end

   assign out_valid  = valid_ff[Q_W-1];
   assign out_quot   = quot_ff[Q_W-1];
   assign out_rem_nz = |rem_ff[Q_W-1];
   assign out_side   = side_ff[Q_W-1];

endmodule

[rtl/piecewise_linear_contrast_stretch_core.sv]
// channel     | ports                                  | handshake
// ------------+----------------------------------------+------------------------------
// request     | req_pixel_in                           | start high, busy low
// response    | rsp_pixel_out, rsp_param_error         | rsp_valid for one cycle
// csr write   | csr_index, csr_wdata                   | csr_we high
//
// one transaction per cycle; each request passes stage 0, stage 1, the divider stages
// and the response register; the divider resolves one quotient bit per pipeline stage
// reset clears all valid bits and loads the default curve; busy stays low
// no stalls: the response side takes every result as it appears
`include "piecewise_linear_contrast_stretch_core_defines.svh"

module piecewise_linear_contrast_stretch_core
   import plcs_pkg::*;
#(
   parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [PIXEL_BITS-1:0]     req_pixel_in,
   output logic                      rsp_valid,
   output logic [PIXEL_BITS-1:0]     rsp_pixel_out,
   output logic                      rsp_param_error,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [PIXEL_BITS-1:0]     csr_wdata
);

   localparam int P       = PIXEL_BITS;
   localparam int LATENCY = P + 4;

   logic [P-1:0] low_thr_ff, high_thr_ff, low_lvl_ff, high_lvl_ff;

   logic           cfg_error;
   logic [P+1:0]   slope_s;
   logic [P+1:0]   slope_neg_s;
   logic           slope_neg;
   logic [P:0]     slope_mag;
   logic [P:0]     den;

   logic           s0_valid_ff, s0_valid_in;
   logic [P-1:0]   s0_diff_ff, s0_diff_in;
   region_type     s0_region_ff, s0_region_in;

   logic           s1_valid_ff;
   logic [2*P:0]   s1_prod_ff;
   side_type       s1_side_ff;

   logic           div_valid;
   logic [P:0]     div_quot;
   logic           div_rem_nz;
   logic [SIDE_BITS-1:0] div_side_bits;
   side_type       div_side;

   logic [P+1:0]   ramp_mag;
   logic [P+2:0]   ramp_mag_ext;
   logic signed [P+2:0] ramp_sum;
   logic [P-1:0]   ramp_sat;

   logic           rsp_valid_ff;
   logic [P-1:0]   rsp_pixel_ff, rsp_pixel_in;
   logic           rsp_error_ff;

   logic           rsp_in_levels;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         low_thr_ff  <= '0;
         high_thr_ff <= '1;
         low_lvl_ff  <= '0;
         high_lvl_ff <= '1;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_LOW_THRESHOLD:  low_thr_ff  <= csr_wdata;
            CSR_HIGH_THRESHOLD: high_thr_ff <= csr_wdata;
            CSR_LOW_LEVEL:      low_lvl_ff  <= csr_wdata;
            CSR_HIGH_LEVEL:     high_lvl_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // curve terms derived from the static configuration
   always_comb begin
      cfg_error   = high_thr_ff < low_thr_ff;
      slope_s     = {2'b00, high_lvl_ff} - {2'b00, low_lvl_ff} + (P+2)'(1);
      slope_neg   = slope_s[P+1];
      slope_neg_s = -slope_s;
      slope_mag   = slope_neg ? slope_neg_s[P:0] : slope_s[P:0];
      den         = {1'b0, high_thr_ff} - {1'b0, low_thr_ff} + (P+1)'(1);
   end

   assign busy = 1'b0;

   // stage 0: classify the pixel
   always_comb begin
      s0_valid_in = start && !busy;
      s0_diff_in  = req_pixel_in - low_thr_ff;
      if (cfg_error) begin
         s0_region_in = REGION_ERROR;
      end else if (req_pixel_in < low_thr_ff) begin
         s0_region_in = REGION_LOW;
      end else if (req_pixel_in > high_thr_ff) begin
         s0_region_in = REGION_HIGH;
      end else begin
         s0_region_in = REGION_RAMP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
      end
      s0_diff_ff   <= s0_diff_in;
      s0_region_ff <= s0_region_in;
   end

   // stage 1: product magnitude
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s0_valid_ff;
      end
      s1_prod_ff        <= (2*P+1)'(s0_diff_ff) * (2*P+1)'(slope_mag);
      s1_side_ff.region <= s0_region_ff;
      s1_side_ff.neg    <= slope_neg;
   end

   plcs_divider #(
      .PIXEL_BITS (P),
      .SIDE_W     (SIDE_BITS)
   ) u_divider (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s1_valid_ff),
      .in_num     (s1_prod_ff),
      .in_den     (den),
      .in_side    (s1_side_ff),
      .out_valid  (div_valid),
      .out_quot   (div_quot),
      .out_rem_nz (div_rem_nz),
      .out_side   (div_side_bits)
   );

   assign div_side = side_type'(div_side_bits);

   // floor of the signed quotient, offset, saturation and selection by region
   always_comb begin
      ramp_mag     = {1'b0, div_quot} + (P+2)'(div_side.neg & div_rem_nz);
      ramp_mag_ext = {1'b0, ramp_mag};
      ramp_sum     = signed'({3'b000, low_lvl_ff})
                   + (div_side.neg ? -signed'(ramp_mag_ext) : signed'(ramp_mag_ext));
      if (ramp_sum[P+2]) begin
         ramp_sat = '0;
      end else if (|ramp_sum[P+1:P]) begin
         ramp_sat = '1;
      end else begin
         ramp_sat = ramp_sum[P-1:0];
      end
      case (div_side.region)
         REGION_LOW:   rsp_pixel_in = low_lvl_ff;
         REGION_HIGH:  rsp_pixel_in = high_lvl_ff;
         REGION_RAMP:  rsp_pixel_in = ramp_sat;
         REGION_ERROR: rsp_pixel_in = '0;
         default:      rsp_pixel_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= div_valid;
      end
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_error_ff <= div_side.region == REGION_ERROR;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_out   = rsp_pixel_ff;
   assign rsp_param_error = rsp_error_ff;

   // response lies between the two levels, in either order
   assign rsp_in_levels = (low_lvl_ff <= high_lvl_ff)
                        ? (rsp_pixel_out >= low_lvl_ff) && (rsp_pixel_out <= high_lvl_ff)
                        : (rsp_pixel_out >= high_lvl_ff) && (rsp_pixel_out <= low_lvl_ff);

   `PLCS_ASSERT_DLY(a_latency, clock, reset, start && !busy, LATENCY, rsp_valid)
   `PLCS_ASSERT_IMP(a_error_zero, clock, reset, rsp_valid && rsp_param_error, rsp_pixel_out == '0)
   `PLCS_ASSERT_IMP(a_within_levels, clock, reset, rsp_valid && !rsp_param_error, rsp_in_levels)

endmodule
